FILE: design/scs_pkg.sv
// ============================================================================
// scs_pkg: speaking clock sequencer package
// Widths, codes, register map and item types shared by the sequencer files.
// ============================================================================
package scs_pkg;

    localparam int NUM_HOURS   = 24;
    localparam int NUM_MINUTES = 60;
    localparam int POS_WIDTH   = 20;

    localparam int VAL_W    = 20;
    localparam int OP_W     = 2;
    localparam int AHR_W    = 5;
    localparam int AMN_W    = 6;
    localparam int TIDX_W   = 8;
    localparam int SEG_W    = 3;
    localparam int CLIP_W   = 8;
    localparam int WIDE_W   = (POS_WIDTH > VAL_W) ? POS_WIDTH : VAL_W;

    localparam int HR_W     = $clog2(NUM_HOURS);
    localparam int MN_W     = $clog2(NUM_MINUTES);
    localparam int TABLE_DEPTH = NUM_HOURS + 2 * NUM_MINUTES;

    localparam int CLIP_HR_BASE = 2;
    localparam int CLIP_MN_BASE = 2 + NUM_HOURS;
    localparam int CLIP_SC_BASE = 2 + NUM_HOURS + NUM_MINUTES;

    localparam logic [VAL_W-1:0]     BOUND_RST = VAL_W'(16000);
    localparam logic [POS_WIDTH-1:0] POS_MAX   = '1;

    localparam int NUM_REGS = 7;
    localparam int RIDX_W   = $clog2(NUM_REGS);
    localparam int PADDR_W  = RIDX_W + 2;
    localparam int PDATA_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SYNC = 2'd0,
        OP_TICK = 2'd1,
        OP_LOAD = 2'd2
    } t_opcode;

    typedef enum logic [SEG_W-1:0] {
        SEG_BEEP   = 3'd0,
        SEG_INTRO  = 3'd1,
        SEG_HOUR   = 3'd2,
        SEG_MINUTE = 3'd3,
        SEG_SECOND = 3'd4,
        SEG_PAUSE  = 3'd5
    } t_segment;

    typedef enum logic [RIDX_W-1:0] {
        REG_BEEP_END     = 3'd0,
        REG_INTRO_END    = 3'd1,
        REG_HOUR_END     = 3'd2,
        REG_MINUTE_END   = 3'd3,
        REG_SECOND_END   = 3'd4,
        REG_BEEP_LENGTH  = 3'd5,
        REG_INTRO_LENGTH = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [VAL_W-1:0]  start_position;
        logic [AHR_W-1:0]  announce_hour;
        logic [AMN_W-1:0]  announce_minute;
        logic [AMN_W-1:0]  announce_second;
        logic [TIDX_W-1:0] table_index;
        logic [VAL_W-1:0]  table_value;
    } t_in_item;

    typedef struct packed {
        t_segment          segment;
        logic [CLIP_W-1:0] clip_number;
        logic [VAL_W-1:0]  clip_offset;
        logic              audible;
    } t_result;

endpackage

FILE: design/scs_in_if.sv
// ============================================================================
// scs_in_if: sequencer input channel
// Valid/ready channel carrying one sync, tick or load item per transfer.
// ============================================================================
interface scs_in_if;
    import scs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [VAL_W-1:0]  start_position;
    logic [AHR_W-1:0]  announce_hour;
    logic [AMN_W-1:0]  announce_minute;
    logic [AMN_W-1:0]  announce_second;
    logic [TIDX_W-1:0] table_index;
    logic [VAL_W-1:0]  table_value;

    modport source (
        output valid, opcode, start_position, announce_hour, announce_minute,
               announce_second, table_index, table_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_position, announce_hour, announce_minute,
               announce_second, table_index, table_value,
        output ready
    );
endinterface

FILE: design/scs_out_if.sv
// ============================================================================
// scs_out_if: sequencer result channel
// Valid/ready channel carrying one playback result per transfer.
// ============================================================================
interface scs_out_if;
    import scs_pkg::*;

    logic              valid;
    logic              ready;
    logic [SEG_W-1:0]  segment;
    logic [CLIP_W-1:0] clip_number;
    logic [VAL_W-1:0]  clip_offset;
    logic              audible;

    modport source (
        output valid, segment, clip_number, clip_offset, audible,
        input  ready
    );

    modport sink (
        input  valid, segment, clip_number, clip_offset, audible,
        output ready
    );
endinterface

FILE: design/speaking_clock_sequencer.sv
// ============================================================================
// speaking_clock_sequencer: speaking clock playback sequencer
// Steps the play position through beep, intro, hour, minute and second clips.
// ============================================================================
// One transfer is taken every clock cycle while the result register is not
// stalled. Each item passes through an input register, then one pass of
// boundary compares, an offset subtract and a length compare into the result
// register. The three clip length tables are on-chip memories read ahead at
// the next hour, minute and second index, so the length of the clip in play
// is always held in a register and no tick waits on a table read. A stalled
// result register holds one result while one further item waits in the input
// register. Every item (sync, tick, load) returns exactly one result.
module speaking_clock_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    scs_in_if.sink                          i_in,
    scs_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scs_pkg::PADDR_W-1:0]     paddr,
    input  logic [scs_pkg::PDATA_W-1:0]     pwdata,
    output logic [scs_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import scs_pkg::*;

    logic [VAL_W-1:0]     r_beep_end, r_intro_end, r_hour_end, r_minute_end, r_second_end;
    logic [VAL_W-1:0]     r_beep_length, r_intro_length;

    logic                 r_in_valid;
    t_in_item             r_in;
    logic                 r_out_valid;
    t_result              r_res;
    t_result              n_res;

    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [HR_W-1:0]      r_hour, n_hour;
    logic [MN_W-1:0]      r_minute, n_minute;
    logic [MN_W-1:0]      r_second, n_second;

    logic [VAL_W-1:0]     mem_hr [NUM_HOURS];
    logic [VAL_W-1:0]     mem_mn [NUM_MINUTES];
    logic [VAL_W-1:0]     mem_sc [NUM_MINUTES];
    logic [VAL_W-1:0]     r_hr_len, r_mn_len, r_sc_len;

    logic                 hr_we, mn_we, sc_we;
    logic [HR_W-1:0]      hr_wa;
    logic [MN_W-1:0]      mn_wa, sc_wa;

    logic                 advance;
    logic                 cfg_we;
    t_reg_idx             cfg_idx;

    t_segment             tk_seg;
    logic [CLIP_W-1:0]    tk_clip;
    logic [WIDE_W-1:0]    tk_pos, tk_base, tk_offset;
    logic [VAL_W-1:0]     tk_len;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_end     <= BOUND_RST;
            r_intro_end    <= BOUND_RST;
            r_hour_end     <= BOUND_RST;
            r_minute_end   <= BOUND_RST;
            r_second_end   <= BOUND_RST;
            r_beep_length  <= '0;
            r_intro_length <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_BEEP_END:     r_beep_end     <= pwdata[VAL_W-1:0];
                REG_INTRO_END:    r_intro_end    <= pwdata[VAL_W-1:0];
                REG_HOUR_END:     r_hour_end     <= pwdata[VAL_W-1:0];
                REG_MINUTE_END:   r_minute_end   <= pwdata[VAL_W-1:0];
                REG_SECOND_END:   r_second_end   <= pwdata[VAL_W-1:0];
                REG_BEEP_LENGTH:  r_beep_length  <= pwdata[VAL_W-1:0];
                REG_INTRO_LENGTH: r_intro_length <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BEEP_END:     prdata = PDATA_W'(r_beep_end);
            REG_INTRO_END:    prdata = PDATA_W'(r_intro_end);
            REG_HOUR_END:     prdata = PDATA_W'(r_hour_end);
            REG_MINUTE_END:   prdata = PDATA_W'(r_minute_end);
            REG_SECOND_END:   prdata = PDATA_W'(r_second_end);
            REG_BEEP_LENGTH:  prdata = PDATA_W'(r_beep_length);
            REG_INTRO_LENGTH: prdata = PDATA_W'(r_intro_length);
            default:          prdata = '0;
        endcase
    end

    // input register and result register
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.opcode          <= i_in.opcode;
            r_in.start_position  <= i_in.start_position;
            r_in.announce_hour   <= i_in.announce_hour;
            r_in.announce_minute <= i_in.announce_minute;
            r_in.announce_second <= i_in.announce_second;
            r_in.table_index     <= i_in.table_index;
            r_in.table_value     <= i_in.table_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.segment     = r_res.segment;
    assign o_out.clip_number = r_res.clip_number;
    assign o_out.clip_offset = r_res.clip_offset;
    assign o_out.audible     = r_res.audible;

    // segment selection for a tick
    assign tk_pos = WIDE_W'(r_pos);

    always_comb begin
        tk_seg  = SEG_PAUSE;
        tk_clip = '0;
        tk_base = '0;
        tk_len  = '0;
        if (tk_pos < WIDE_W'(r_beep_end)) begin
            tk_seg  = SEG_BEEP;
            tk_len  = r_beep_length;
        end else if (tk_pos < WIDE_W'(r_intro_end)) begin
            tk_seg  = SEG_INTRO;
            tk_clip = CLIP_W'(1);
            tk_base = WIDE_W'(r_beep_end);
            tk_len  = r_intro_length;
        end else if (tk_pos < WIDE_W'(r_hour_end)) begin
            tk_seg  = SEG_HOUR;
            tk_clip = CLIP_W'(CLIP_HR_BASE) + CLIP_W'(r_hour);
            tk_base = WIDE_W'(r_intro_end);
            tk_len  = r_hr_len;
        end else if (tk_pos < WIDE_W'(r_minute_end)) begin
            tk_seg  = SEG_MINUTE;
            tk_clip = CLIP_W'(CLIP_MN_BASE) + CLIP_W'(r_minute);
            tk_base = WIDE_W'(r_hour_end);
            tk_len  = r_mn_len;
        end else if (tk_pos < WIDE_W'(r_second_end)) begin
            tk_seg  = SEG_SECOND;
            tk_clip = CLIP_W'(CLIP_SC_BASE) + CLIP_W'(r_second);
            tk_base = WIDE_W'(r_minute_end);
            tk_len  = r_sc_len;
        end
    end

    assign tk_offset = tk_pos - tk_base;

    // item processing
    always_comb begin
        n_pos    = r_pos;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        hr_we    = 1'b0;
        mn_we    = 1'b0;
        sc_we    = 1'b0;
        hr_wa    = HR_W'(r_in.table_index);
        mn_wa    = MN_W'(r_in.table_index - TIDX_W'(NUM_HOURS));
        sc_wa    = MN_W'(r_in.table_index - TIDX_W'(NUM_HOURS + NUM_MINUTES));
        n_res    = '{segment: SEG_BEEP, clip_number: '0, clip_offset: '0, audible: 1'b0};
        if (advance) begin
            case (t_opcode'(r_in.opcode))
                OP_SYNC: begin
                    n_pos  = POS_WIDTH'(r_in.start_position);
                    n_hour = (r_in.announce_hour > AHR_W'(NUM_HOURS - 1))
                           ? HR_W'(NUM_HOURS - 1) : HR_W'(r_in.announce_hour);
                    n_minute = (r_in.announce_minute > AMN_W'(NUM_MINUTES - 1))
                             ? MN_W'(NUM_MINUTES - 1) : MN_W'(r_in.announce_minute);
                    n_second = (r_in.announce_second > AMN_W'(NUM_MINUTES - 1))
                             ? MN_W'(NUM_MINUTES - 1) : MN_W'(r_in.announce_second);
                end
                OP_LOAD: begin
                    if (r_in.table_index < TIDX_W'(NUM_HOURS)) begin
                        hr_we = 1'b1;
                    end else if (r_in.table_index < TIDX_W'(NUM_HOURS + NUM_MINUTES)) begin
                        mn_we = 1'b1;
                    end else if (r_in.table_index < TIDX_W'(TABLE_DEPTH)) begin
                        sc_we = 1'b1;
                    end
                end
                OP_TICK: begin
                    n_res.segment = tk_seg;
                    if (tk_seg != SEG_PAUSE) begin
                        n_res.clip_number = tk_clip;
                        n_res.clip_offset = tk_offset[VAL_W-1:0];
                        n_res.audible     = tk_offset < WIDE_W'(tk_len);
                        if (tk_len != '0 && r_pos != POS_MAX) begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end else begin
            r_pos    <= n_pos;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    // length tables, read ahead at the next index with write-through
    always_ff @(posedge i_clk) begin
        if (hr_we) begin
            mem_hr[hr_wa] <= r_in.table_value;
        end
        r_hr_len <= (hr_we && hr_wa == n_hour) ? r_in.table_value : mem_hr[n_hour];
    end

    always_ff @(posedge i_clk) begin
        if (mn_we) begin
            mem_mn[mn_wa] <= r_in.table_value;
        end
        r_mn_len <= (mn_we && mn_wa == n_minute) ? r_in.table_value : mem_mn[n_minute];
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            mem_sc[sc_wa] <= r_in.table_value;
        end
        r_sc_len <= (sc_we && sc_wa == n_second) ? r_in.table_value : mem_sc[n_second];
    end

`ifndef NO_ASSERTIONS
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour <= HR_W'(NUM_HOURS - 1))
        else $error("hour register beyond last hour");

    a_pause_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && t_opcode'(r_in.opcode) == OP_TICK && tk_seg == SEG_PAUSE)
        |=> (r_res.segment == SEG_PAUSE && !r_res.audible && r_res.clip_offset == '0
             && $stable(r_pos)))
        else $error("pause tick not silent or position moved");

    a_pos_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_MAX && !(advance && t_opcode'(r_in.opcode) == OP_SYNC))
        |=> r_pos == POS_MAX)
        else $error("play position wrapped");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_res))
        else $error("stalled result lost");
`endif

endmodule
